FILE: design/mcw_pkg.sv
// Shared types and constants for the multi-channel watchdog.
// Holds the request and result beat structs, the register map and status codes.
// No dependencies.
package mcw_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned STATUS_W = 2;

  // APB register map: three 32-bit registers at byte offsets 0, 4 and 8.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Reset value of the sweep period, in ticks.
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 24'd1000;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_CHECKIN    = 2'd2,
    REQ_TICK       = 2'd3
  } req_e;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_REG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNRESP  = 2'd2;

  // Register indexes (word address).
  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_REPORT      = 2'd1,
    REG_INIT_PERIOD = 2'd2
  } reg_idx_e;

  // One request beat.
  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [CH_W-1:0]     channel;
    logic [PERIOD_W-1:0] timeout_ticks;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CH_W-1:0]     failed_channel;
    logic                last;
    logic                sticky_error;
    logic [PERIOD_W-1:0] sweep_period;
  } out_t;

  // Configuration seen by the controller.
  typedef struct packed {
    logic                enable;
    logic                report;
    logic                period_load;
    logic [PERIOD_W-1:0] period_value;
  } cfg_t;

endpackage

FILE: design/mcw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module mcw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mcw_regs.sv
// APB configuration registers of the watchdog: enable, report and initial period.
// Depends on mcw_pkg.
module mcw_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mcw_pkg::APB_AW-1:0] paddr,
  input  logic [mcw_pkg::APB_DW-1:0] pwdata,
  output logic [mcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output mcw_pkg::cfg_t              cfg_o
);
  import mcw_pkg::*;

  logic                enable_q, enable_d;
  logic                report_q, report_d;
  logic [PERIOD_W-1:0] init_q, init_d;
  logic                wr_en;
  reg_idx_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Write decode.
  always_comb begin
    enable_d = enable_q;
    report_d = report_q;
    init_d   = init_q;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLE:      enable_d = pwdata[0];
        REG_REPORT:      report_d = pwdata[0];
        REG_INIT_PERIOD: init_d   = pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ENABLE:      prdata = {{(APB_DW-1){1'b0}}, enable_q};
      REG_REPORT:      prdata = {{(APB_DW-1){1'b0}}, report_q};
      REG_INIT_PERIOD: prdata = {{(APB_DW-PERIOD_W){1'b0}}, init_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      report_q <= 1'b1;
      init_q   <= RESET_PERIOD;
    end else begin
      enable_q <= enable_d;
      report_q <= report_d;
      init_q   <= init_d;
    end
  end

  // A write of the initial period also reloads the live sweep period.
  always_comb begin
    cfg_o.enable       = enable_q;
    cfg_o.report       = report_q;
    cfg_o.period_load  = wr_en && (idx == REG_INIT_PERIOD);
    cfg_o.period_value = pwdata[PERIOD_W-1:0];
  end

endmodule

FILE: design/mcw_ctrl.sv
// Request sequencer and sweep engine of the watchdog; holds the channel table
// in two RAMs (timeouts, check-in times). Depends on mcw_pkg and mcw_ram.
module mcw_ctrl #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mcw_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mcw_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mcw_pkg::out_t out_data_o
);
  import mcw_pkg::*;

  localparam int unsigned AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned CMP_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_CHANNELS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  state_e                  state_q, state_d;
  in_t                     item_q, item_d;
  logic [TIME_WIDTH-1:0]   now_q, now_d;
  logic [PERIOD_W-1:0]     sleep_q, sleep_d;
  logic [PERIOD_W-1:0]     period_q, period_d;
  logic                    pending_q, pending_d;
  logic                    error_q, error_d;
  logic [NUM_CHANNELS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    s1_valid_q, s1_valid_d;
  logic [AW-1:0]           s1_idx_q, s1_idx_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [AW-1:0]           pend_idx_q, pend_idx_d;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_q, out_d;

  // Table RAM ports.
  logic                    to_we, ck_we, rd_en;
  logic [AW-1:0]           wr_addr;
  logic [TIME_WIDTH-1:0]   ck_wdata;
  logic [PERIOD_W-1:0]     to_rdata;
  logic [TIME_WIDTH-1:0]   ck_rdata;

  // Helpers.
  logic                    out_free;
  logic                    ch_in_range;
  logic [AW-1:0]           ch_addr;
  logic [TIME_WIDTH-1:0]   now_inc;
  logic [PERIOD_W-1:0]     sleep_inc;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic                    fail;
  logic                    stall;
  logic                    emit;
  logic [STATUS_W-1:0]     emit_status;
  logic [CH_W-1:0]         emit_ch;
  logic                    emit_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign ch_in_range = 32'(item_q.channel) < NUM_CHANNELS;
  assign ch_addr     = AW'(item_q.channel);
  assign now_inc     = now_q + 1'b1;
  assign sleep_inc   = (sleep_q != '1) ? sleep_q + 1'b1 : sleep_q;

  // Sweep evaluation of the entry whose RAM data arrived this cycle.
  assign elapsed = now_q - ck_rdata;
  assign fail    = s1_valid_q && valid_q[s1_idx_q] &&
                   (CMP_W'(elapsed) > CMP_W'(to_rdata));
  // A second failure cannot be taken until the held one has gone out.
  assign stall   = fail && cfg_i.report && pend_valid_q && !out_free;

  mcw_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (NUM_CHANNELS)
  ) u_timeout_ram (
    .clk_i   (clk_i),
    .we_i    (to_we),
    .waddr_i (wr_addr),
    .wdata_i (item_q.timeout_ticks),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (to_rdata)
  );

  mcw_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (NUM_CHANNELS)
  ) u_checkin_ram (
    .clk_i   (clk_i),
    .we_i    (ck_we),
    .waddr_i (wr_addr),
    .wdata_i (ck_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (ck_rdata)
  );

  assign wr_addr  = ch_addr;
  assign ck_wdata = now_q;

  // Next-state logic. Writes happen only in ST_EXEC and reads only in ST_SWEEP,
  // so table accesses never overlap.
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    now_d        = now_q;
    sleep_d      = sleep_q;
    period_d     = period_q;
    pending_d    = pending_q;
    error_d      = error_q;
    valid_d      = valid_q;
    rd_cnt_d     = rd_cnt_q;
    s1_valid_d   = s1_valid_q;
    s1_idx_d     = s1_idx_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    to_we        = 1'b0;
    ck_we        = 1'b0;
    rd_en        = 1'b0;
    emit         = 1'b0;
    emit_status  = STATUS_OK;
    emit_ch      = '0;
    emit_last    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          emit    = 1'b1;
          emit_ch = item_q.channel;
          unique case (req_e'(item_q.req_type))
            REQ_REGISTER: begin
              if (ch_in_range) begin
                if (!valid_q[ch_addr]) begin
                  valid_d[ch_addr] = 1'b1;
                  to_we            = 1'b1;
                  ck_we            = 1'b1;
                end
                if (item_q.timeout_ticks < period_q) begin
                  period_d = item_q.timeout_ticks;
                end
                pending_d = 1'b1;
              end
            end
            REQ_UNREGISTER: begin
              if (ch_in_range) begin
                valid_d[ch_addr] = 1'b0;
              end
            end
            REQ_CHECKIN: begin
              if (ch_in_range && valid_q[ch_addr]) begin
                ck_we = 1'b1;
              end else begin
                emit_status = STATUS_NOT_REG;
              end
            end
            REQ_TICK: begin
              now_d   = now_inc;
              emit_ch = '0;
              if (cfg_i.enable) begin
                sleep_d = sleep_inc;
                if (pending_q || (sleep_inc >= period_q)) begin
                  // Start a sweep; its results come from ST_SWEEP.
                  pending_d    = 1'b0;
                  sleep_d      = '0;
                  rd_cnt_d     = '0;
                  s1_valid_d   = 1'b0;
                  pend_valid_d = 1'b0;
                  emit         = 1'b0;
                  state_d      = ST_SWEEP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SWEEP: begin
        if (!stall) begin
          // Take the result of the entry in the check stage.
          if (fail) begin
            if (cfg_i.report) begin
              if (pend_valid_q) begin
                emit        = 1'b1;
                emit_status = STATUS_UNRESP;
                emit_ch     = CH_W'(pend_idx_q);
                emit_last   = 1'b0;
              end
              pend_valid_d = 1'b1;
              pend_idx_d   = s1_idx_q;
            end else begin
              error_d = 1'b1;
            end
          end
          // Issue the next table read.
          if (rd_cnt_q < LAST_CNT) begin
            rd_en      = 1'b1;
            s1_valid_d = 1'b1;
            s1_idx_d   = rd_cnt_q[AW-1:0];
            rd_cnt_d   = rd_cnt_q + 1'b1;
          end else begin
            s1_valid_d = 1'b0;
          end
          // All entries checked: send the held failure or a clean result.
          if (!(rd_cnt_q < LAST_CNT) && !s1_valid_q && out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
            if (pend_valid_q) begin
              emit_status = STATUS_UNRESP;
              emit_ch     = CH_W'(pend_idx_q);
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // The user must make configuration writes only while idle; the block itself does not enforce this.
    if (cfg_i.period_load) begin
      period_d = cfg_i.period_value;
    end

    // Load the result register.
    if (emit) begin
      out_valid_d          = 1'b1;
      out_d.status         = emit_status;
      out_d.failed_channel = emit_ch;
      out_d.last           = emit_last;
      out_d.sticky_error   = error_d;
      out_d.sweep_period   = period_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      now_q        <= '0;
      sleep_q      <= '0;
      period_q     <= RESET_PERIOD;
      pending_q    <= 1'b0;
      error_q      <= 1'b0;
      valid_q      <= '0;
      rd_cnt_q     <= '0;
      s1_valid_q   <= 1'b0;
      s1_idx_q     <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      now_q        <= now_d;
      sleep_q      <= sleep_d;
      period_q     <= period_d;
      pending_q    <= pending_d;
      error_q      <= error_d;
      valid_q      <= valid_d;
      rd_cnt_q     <= rd_cnt_d;
      s1_valid_q   <= s1_valid_d;
      s1_idx_q     <= s1_idx_d;
      pend_valid_q <= pend_valid_d;
      pend_idx_q   <= pend_idx_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/multi_channel_watchdog.sv
// Multi-channel watchdog. An accepted request beat is registered; its result beat
// is loaded into the result register once the result side is free. Requests are
// taken one at a time: no new request is accepted until the last one is done. A
// tick that sweeps reads the table one channel per cycle unless a report stalls.
// Reset: asynchronous, clears valid marks and counters; no clearing pass is run.
// Depends on mcw_pkg, mcw_regs, mcw_ctrl and mcw_ram.
module multi_channel_watchdog #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mcw_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mcw_pkg::out_t              out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mcw_pkg::APB_AW-1:0] paddr,
  input  logic [mcw_pkg::APB_DW-1:0] pwdata,
  output logic [mcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import mcw_pkg::*;

  cfg_t cfg;

  mcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcw_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/mcw_checker.sv
// Port-level checks for the multi-channel watchdog, bound to the top level.
// Depends on mcw_pkg and multi_channel_watchdog.
module mcw_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mcw_pkg::out_t out_data_o
);
  import mcw_pkg::*;

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Requests are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while one is in flight");

  // Only failure reports may be followed by more results of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == STATUS_UNRESP)
    else $error("non-final result that is not a failure report");

  // A check-in error is always a request's only result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_NOT_REG |-> out_data_o.last)
    else $error("check-in error not marked last");

endmodule

bind multi_channel_watchdog mcw_checker u_mcw_checker (.*);
